// File: rtl/cmsd_pkg.sv
// Shared constants and types for the centered moving standard deviation block.
`default_nettype none
package cmsd_pkg;
  // Default half window and sample width
  localparam int HALF_WINDOW_DEF  = 10;
  localparam int SAMPLE_WIDTH_DEF = 24;
  // Width of the window count field
  localparam int COUNT_W          = 5;

  // Classification of one item, handed from front to back
  typedef struct packed {
    logic col_end;   // last sample of the column, flush pending results
    logic emit_now;  // one result due for the position HALF_WINDOW back
  } cmsd_ctl_t;
endpackage
`default_nettype wire

// File: rtl/cmsd_if.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface cmsd_in_if #(
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           column_end;

  modport source (output valid, sample, column_end, input ready);
  modport sink   (input valid, sample, column_end, output ready);
endinterface

interface cmsd_out_if #(
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [SAMPLE_WIDTH-1:0]       std_dev;
  logic [cmsd_pkg::COUNT_W-1:0]  window_count;
  logic                          last_of_column;

  modport source (output valid, std_dev, window_count, last_of_column, input ready);
  modport sink   (input valid, std_dev, window_count, last_of_column, output ready);
endinterface
`default_nettype wire

// File: rtl/centered_moving_std_dev_core.sv
// Top level of the centered moving standard deviation block.
//
//  channel  direction  payload                                      handshake
//  in_ch    sink       sample, column_end                           valid/ready
//  out_ch   source     std_dev, window_count, last_of_column        valid/ready
//
// Each result is computed by the one-bit-per-cycle divider and the two-bit-per-cycle
// square root; the back takes no new item until it is through with the last one.
// A column end flushes up to HALF_WINDOW+1 results.
// Reset is synchronous and clears the queue, the column counters and out valid.
// A two-entry queue lets the input side accept up to two items while the back stalls.
`default_nettype none
module centered_moving_std_dev_core #(
  parameter int HALF_WINDOW  = cmsd_pkg::HALF_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cmsd_in_if.sink     in_ch,
  cmsd_out_if.source  out_ch
);
  localparam int QW = SAMPLE_WIDTH + $bits(cmsd_pkg::cmsd_ctl_t);

  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  logic [SAMPLE_WIDTH-1:0]    f_sample;
  cmsd_pkg::cmsd_ctl_t        f_ctl;
  logic [QW-1:0]              q_rd;
  cmsd_pkg::cmsd_ctl_t        b_ctl;

  assign b_ctl = q_rd[QW-1:SAMPLE_WIDTH];

  cmsd_front #(.HALF_WINDOW(HALF_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_sample (f_sample),
    .q_ctl    (f_ctl)
  );

  cmsd_queue #(.DATA_W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_sample}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd),
    .empty     (q_empty)
  );

  cmsd_back #(.HALF_WINDOW(HALF_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_sample (q_rd[SAMPLE_WIDTH-1:0]),
    .q_ctl    (b_ctl),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire

// File: rtl/cmsd_queue.sv
// Two-entry queue between the front and the back.
`default_nettype none
module cmsd_queue #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output logic                   empty
);
  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/cmsd_front.sv
// Front: accepts items, tracks the column fill and classifies each item.
`default_nettype none
module cmsd_front #(
  parameter int HALF_WINDOW  = cmsd_pkg::HALF_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cmsd_in_if.sink                    in_ch,
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [SAMPLE_WIDTH-1:0]    q_sample,
  output cmsd_pkg::cmsd_ctl_t        q_ctl
);
  localparam int RING_DEPTH = 2 * HALF_WINDOW + 1;
  localparam int CW         = $clog2(RING_DEPTH + 1);

  logic [CW-1:0] seen_r;
  logic [CW-1:0] seen_nxt;

  assign in_ch.ready = ~q_full;
  assign q_push      = in_ch.valid & ~q_full;
  assign q_sample    = in_ch.sample;

  // samples in the column after this one, saturating at the ring depth
  always_comb begin
    seen_nxt = (seen_r == CW'(RING_DEPTH)) ? seen_r : seen_r + CW'(1);
    q_ctl.col_end  = in_ch.column_end;
    q_ctl.emit_now = (seen_nxt > CW'(HALF_WINDOW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (q_push) begin
      seen_r <= in_ch.column_end ? '0 : seen_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/cmsd_back.sv
// Back: sample ring, window sums, exact variance divide and square root.
`default_nettype none
module cmsd_back #(
  parameter int HALF_WINDOW  = cmsd_pkg::HALF_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  output logic                          q_pop,
  input  wire logic [SAMPLE_WIDTH-1:0]  q_sample,
  input  wire cmsd_pkg::cmsd_ctl_t      q_ctl,
  cmsd_out_if.source                    out_ch
);
  localparam int SW         = SAMPLE_WIDTH;
  localparam int RING_DEPTH = 2 * HALF_WINDOW + 1;
  localparam int CW         = $clog2(RING_DEPTH + 1);
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int MW         = SW + CW;          // sum and its magnitude
  localparam int SQW        = 2 * SW + CW;      // sum of squares
  localparam int NW         = 2 * SW + 2 * CW;  // numerator and quotient
  localparam int RW         = NW / 2;           // square root
  localparam int DW         = 2 * CW;           // n squared
  localparam int BW         = $clog2(NW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_START, ST_SUM, ST_MUL, ST_SQ, ST_SUB, ST_DIV, ST_SQRT, ST_OUT
  } state_t;

  state_t                state_r;
  logic [SW-1:0]         ring [RING_DEPTH];
  logic [AW-1:0]         wslot_r;
  logic [CW-1:0]         seen_r;
  logic [SW-1:0]         sample_r;
  cmsd_pkg::cmsd_ctl_t   ctl_r;
  logic [CW-1:0]         back_r;
  logic [CW-1:0]         n_r;
  logic [AW-1:0]         rd_addr_r;
  logic [CW-1:0]         issue_r;
  logic                  rv1_r;
  logic                  rv2_r;
  logic signed [SW-1:0]  rd_data_r;
  logic signed [SW-1:0]  val2_r;
  logic [2*SW-1:0]       sq_r;
  logic signed [MW-1:0]  s1_r;
  logic [SQW-1:0]        s2_r;
  logic [NW-1:0]         num_r;
  logic [NW-1:0]         mcand_r;
  logic [MW-1:0]         mplier_r;
  logic [NW-1:0]         sqacc_r;
  logic [DW-1:0]         d_r;
  logic [DW-1:0]         rem_r;
  logic [RW-1:0]         root_r;
  logic [RW:0]           srem_r;
  logic [BW-1:0]         bitcnt_r;
  logic                  out_valid_r;
  logic [SW-1:0]         std_r;
  logic [cmsd_pkg::COUNT_W-1:0] wcount_r;
  logic                  last_r;

  logic                  rd_en;
  logic [CW-1:0]         seen_new;
  logic [CW:0]           far1;
  logic [CW-1:0]         n_start;
  logic [AW-1:0]         newest;
  logic [SW-1:0]         mag;
  logic [2*SW-1:0]       sq_nxt;
  logic [MW-1:0]         s1_mag;
  logic [DW:0]           div_try;
  logic [RW+2:0]         sqrt_rem;
  logic [RW+2:0]         sqrt_try;
  logic                  out_load;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;
  assign rd_en = (state_r == ST_SUM) && (issue_r < n_r);

  assign out_ch.valid          = out_valid_r;
  assign out_ch.std_dev        = std_r;
  assign out_ch.window_count   = wcount_r;
  assign out_ch.last_of_column = last_r;

  // helper values for the sequencer
  always_comb begin
    seen_new = (seen_r == CW'(RING_DEPTH)) ? seen_r : seen_r + CW'(1);
    far1     = {1'b0, back_r} + (CW + 1)'(HALF_WINDOW + 1);
    n_start  = (far1 > {1'b0, seen_r}) ? seen_r : far1[CW-1:0];
    newest   = (wslot_r == '0) ? AW'(RING_DEPTH - 1) : wslot_r - AW'(1);
    mag      = rd_data_r[SW-1] ? SW'(-rd_data_r) : SW'(rd_data_r);
    sq_nxt   = {{SW{1'b0}}, mag} * {{SW{1'b0}}, mag};
    s1_mag   = s1_r[MW-1] ? MW'(-s1_r) : MW'(s1_r);
    div_try  = {rem_r, num_r[NW-1]};
    sqrt_rem = {srem_r, num_r[NW-1:NW-2]};
    sqrt_try = {1'b0, root_r, 2'b01};
    out_load = !out_valid_r || out_ch.ready;
  end

  // sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE) begin
      ring[wslot_r] <= sample_r;
    end
    if (rd_en) begin
      rd_data_r <= ring[rd_addr_r];
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wslot_r     <= '0;
      seen_r      <= '0;
      rv1_r       <= 1'b0;
      rv2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken; ST_OUT reloads it in the same cycle
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        // take the next classified item
        ST_IDLE: begin
          if (!q_empty) begin
            sample_r <= q_sample;
            ctl_r    <= q_ctl;
            state_r  <= ST_WRITE;
          end
        end
        // store the sample, pick the first result position
        ST_WRITE: begin
          wslot_r <= (wslot_r == AW'(RING_DEPTH - 1)) ? '0 : wslot_r + AW'(1);
          seen_r  <= seen_new;
          back_r  <= ctl_r.emit_now ? CW'(HALF_WINDOW) : seen_new - CW'(1);
          state_r <= (ctl_r.emit_now || ctl_r.col_end) ? ST_START : ST_IDLE;
        end
        // window size and newest slot for this result
        ST_START: begin
          n_r       <= n_start;
          rd_addr_r <= newest;
          issue_r   <= '0;
          rv1_r     <= 1'b0;
          rv2_r     <= 1'b0;
          s1_r      <= '0;
          s2_r      <= '0;
          state_r   <= ST_SUM;
        end
        // read, square and accumulate the newest n samples
        ST_SUM: begin
          if (rd_en) begin
            rd_addr_r <= (rd_addr_r == '0) ? AW'(RING_DEPTH - 1) : rd_addr_r - AW'(1);
            issue_r   <= issue_r + CW'(1);
          end
          rv1_r <= rd_en;
          rv2_r <= rv1_r;
          if (rv1_r) begin
            val2_r <= rd_data_r;
            sq_r   <= sq_nxt;
          end
          if (rv2_r) begin
            s1_r <= s1_r + MW'(val2_r);
            s2_r <= s2_r + SQW'(sq_r);
          end
          if (!rd_en && !rv1_r && !rv2_r) state_r <= ST_MUL;
        end
        // n * S2, and set up the shift-add square of |S1|
        ST_MUL: begin
          num_r    <= NW'(n_r) * NW'(s2_r);
          mcand_r  <= NW'(s1_mag);
          mplier_r <= s1_mag;
          sqacc_r  <= '0;
          state_r  <= ST_SQ;
        end
        ST_SQ: begin
          if (mplier_r == '0) begin
            state_r <= ST_SUB;
          end else begin
            if (mplier_r[0]) sqacc_r <= sqacc_r + mcand_r;
            mcand_r  <= {mcand_r[NW-2:0], 1'b0};
            mplier_r <= {1'b0, mplier_r[MW-1:1]};
          end
        end
        // numerator and divisor n^2
        ST_SUB: begin
          num_r    <= num_r - sqacc_r;
          d_r      <= DW'(n_r) * DW'(n_r);
          rem_r    <= '0;
          bitcnt_r <= '0;
          state_r  <= ST_DIV;
        end
        // restoring divide, one quotient bit per cycle into num_r
        ST_DIV: begin
          if (div_try >= {1'b0, d_r}) begin
            rem_r <= DW'(div_try - {1'b0, d_r});
            num_r <= {num_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= div_try[DW-1:0];
            num_r <= {num_r[NW-2:0], 1'b0};
          end
          if (bitcnt_r == BW'(NW - 1)) begin
            bitcnt_r <= '0;
            srem_r   <= '0;
            root_r   <= '0;
            state_r  <= ST_SQRT;
          end else begin
            bitcnt_r <= bitcnt_r + BW'(1);
          end
        end
        // digit-by-digit square root, two radicand bits per cycle
        ST_SQRT: begin
          if (sqrt_rem >= sqrt_try) begin
            srem_r <= (RW + 1)'(sqrt_rem - sqrt_try);
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            srem_r <= sqrt_rem[RW:0];
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          num_r <= {num_r[NW-3:0], 2'b00};
          if (bitcnt_r == BW'(RW - 1)) begin
            state_r <= ST_OUT;
          end else begin
            bitcnt_r <= bitcnt_r + BW'(1);
          end
        end
        // hand over the result, then next position or next item
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            std_r       <= root_r[SW-1:0];
            wcount_r    <= cmsd_pkg::COUNT_W'(n_r);
            last_r      <= ctl_r.col_end && (back_r == '0);
            if (ctl_r.col_end && back_r != '0) begin
              back_r  <= back_r - CW'(1);
              state_r <= ST_START;
            end else begin
              if (ctl_r.col_end) begin
                wslot_r <= '0;
                seen_r  <= '0;
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/cmsd_checker.sv
// Port-level assertions for the top level, attached by bind.
`default_nettype none
module cmsd_checker #(
  parameter int HALF_WINDOW  = cmsd_pkg::HALF_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = cmsd_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [SAMPLE_WIDTH-1:0]      std_dev,
  input wire logic [cmsd_pkg::COUNT_W-1:0] window_count,
  input wire logic                         last_of_column
);
  localparam int RING_DEPTH = 2 * HALF_WINDOW + 1;
  localparam logic [SAMPLE_WIDTH-1:0] STD_MAX = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(std_dev) &&
      $stable(window_count) && $stable(last_of_column))
    else $error("result changed while stalled");

  // reset leaves no result pending and the queue open
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // window count stays within the ring
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (RING_DEPTH > 31) ||
      (window_count != '0 && 32'(window_count) <= RING_DEPTH))
    else $error("window count out of range");

  // a deviation never exceeds half the sample span
  a_std: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> std_dev <= STD_MAX)
    else $error("deviation out of range");
endmodule

bind centered_moving_std_dev_core cmsd_checker #(
  .HALF_WINDOW(HALF_WINDOW), .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cmsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .std_dev        (out_ch.std_dev),
  .window_count   (out_ch.window_count),
  .last_of_column (out_ch.last_of_column)
);
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the centered moving standard deviation core.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  localparam int HW    = cmsd_pkg::HALF_WINDOW_DEF;
  localparam int SW    = cmsd_pkg::SAMPLE_WIDTH_DEF;
  localparam int DEPTH = 2 * HW + 1;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

  typedef struct {
    logic [SW-1:0]                std_dev;
    logic [cmsd_pkg::COUNT_W-1:0] window_count;
    logic                         last_of_column;
  } std_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   out_gap = 0;
  bit   out_busy_mode = 1'b1;

  cmsd_in_if  in_ch ();
  cmsd_out_if out_ch ();

  centered_moving_std_dev_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Predictor state: recent samples of the current column
  longint      col_ring [DEPTH];
  int          col_seen = 0;
  int          col_slot = 0;
  std_result_t pending_std[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Std dev of the window centred 'back' positions behind the newest sample
  task automatic push_window_std(int back, bit last);
    int far;
    int n;
    int slot;
    longint sum;
    logic [127:0] sq;
    logic [127:0] num;
    longint unsigned var_q;
    std_result_t r;
    far = back + HW;
    if (far > col_seen - 1) far = col_seen - 1;
    n = far + 1;
    sum = 0;
    sq = '0;
    for (int j = 0; j < n; j++) begin
      slot = (col_slot + DEPTH - 1 - j) % DEPTH;
      sum += col_ring[slot];
      sq += 128'(col_ring[slot] * col_ring[slot]);
    end
    num = sq * 128'(n) - 128'(sum * sum);
    var_q = 64'(num / 128'(n * n));
    r.std_dev = SW'(int_sqrt(var_q));
    r.window_count = cmsd_pkg::COUNT_W'(n);
    r.last_of_column = last;
    pending_std.push_back(r);
  endtask

  task automatic predict_column_std(logic signed [SW-1:0] s, bit col_end);
    int b;
    col_ring[col_slot] = longint'(s);
    col_slot = (col_slot + 1) % DEPTH;
    if (col_seen < DEPTH) col_seen++;
    if (col_seen > HW) push_window_std(HW, 1'b0);
    if (col_end) begin
      b = (col_seen < HW) ? col_seen : HW;
      for (; b > 0; b--) push_window_std(b - 1, b == 1);
      col_seen = 0;
      col_slot = 0;
    end
  endtask

  // Idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one item, predict on acceptance, then idle at random
  task automatic send_sample(logic signed [SW-1:0] s, bit col_end, bit no_idle = 1'b0);
    int gap;
    in_ch.valid = 1'b1;
    in_ch.sample = s;
    in_ch.column_end = col_end;
    do @(posedge clk); while (!in_ch.ready);
    predict_column_std(s, col_end);
    @(negedge clk);
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off until every expected result has arrived
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_std.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return SW'($urandom);
      1: return SW'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      default: return SW'($signed($urandom_range(0, 65536 * 8)) - 65536 * 4);
    endcase
  endfunction

  task automatic send_column(int len, bit no_idle = 1'b0);
    for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1, no_idle);
  endtask

  // Two single-sample columns: each gives one result, std 0, count 1, marked last
  task automatic test_single_sample();
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b1);
  endtask

  // Short columns: one of three samples, then at and just past the half window
  task automatic test_short_columns();
    send_column(3);
    send_column(HW);
    send_column(HW + 1);
    drain_results();
  endtask

  // Long column of extremes, crossing ring wrap and count saturation
  task automatic test_extremes();
    for (int i = 0; i < 24; i++)
      send_sample(i[0] ? S_MAX : S_MIN, i == 23, 1'b1);
    drain_results();
  endtask

  // Random columns, a few without idling and some long ones
  task automatic test_random_columns();
    int sent;
    int len;
    sent = 0;
    while (sent < 400) begin
      out_busy_mode = $urandom_range(0, 4) != 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 60) : $urandom_range(1, 30);
      send_column(len, $urandom_range(0, 5) == 0);
      sent += len;
      if ($urandom_range(0, 7) == 0) drain_results();
    end
    out_busy_mode = 1'b1;
  endtask

  // Result side stall pattern: ready cycles split by random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (!out_busy_mode) begin
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap <= idle_len();
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    std_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_std.size() == 0) begin
        $error("unexpected result std_dev=%0d", out_ch.std_dev);
        err_cnt++;
      end else begin
        e = pending_std.pop_front();
        if (out_ch.std_dev !== e.std_dev) begin
          $error("std_dev exp %0d got %0d", e.std_dev, out_ch.std_dev);
          err_cnt++;
        end
        if (out_ch.window_count !== e.window_count) begin
          $error("window_count exp %0d got %0d", e.window_count, out_ch.window_count);
          err_cnt++;
        end
        if (out_ch.last_of_column !== e.last_of_column) begin
          $error("last_of_column exp %0d got %0d", e.last_of_column,
                 out_ch.last_of_column);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.column_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_single_sample();
    test_short_columns();
    test_extremes();
    test_random_columns();
    drain_results();
    repeat (400) @(posedge clk);
    if (err_cnt == 0 && pending_std.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
